[design/mcis_pkg.sv]
// Shared types and constants for the multichannel IIR smoother.
`timescale 1ns / 1ps

package mcis_pkg;

  localparam int CH_W       = 3;
  localparam int RAW_W      = 16;
  localparam int Q15_W      = 15;
  localparam int MV_W       = 13;
  localparam int OP_A_W     = 16;
  localparam int PROD_W     = 31;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [Q15_W-1:0] Q15_MAX          = 15'h7FFF;
  localparam logic [Q15_W-1:0] WEIGHT_NEW_RESET = 15'd4096;
  localparam logic [Q15_W-1:0] WEIGHT_OLD_RESET = 15'd28672;
  localparam logic [MV_W-1:0]  REF_MV_RESET     = 13'd3300;

  // Millivolt scaling divides by 2^16 - 1.
  localparam logic [16:0] MV_DIVISOR = 17'd65535;

  localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT_NEW = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT_OLD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_MV     = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw_word;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [Q15_W-1:0] filtered;
    logic [MV_W-1:0]  millivolts;
    logic             saturated;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mul_old;
    logic sum;
    logic mul_mv;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

[design/mcis_ctrl.sv]
// Sequencer that steps one word through the shared multiplier schedule.
`timescale 1ns / 1ps

module mcis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mcis_pkg::status_t status,
  output mcis_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_OLD = 3'd1;
  localparam logic [2:0] ST_SUM     = 3'd2;
  localparam logic [2:0] ST_MUL_MV  = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       finish_go;
  logic       take;
  logic       accept;

  assign finish_go = (state_r == ST_FINISH) && status.out_free;
  assign take      = (state_r == ST_IDLE) || finish_go;
  assign in_stall  = !rst_n || !take;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd.load    = accept;
    cmd.mul_old = (state_r == ST_MUL_OLD);
    cmd.sum     = (state_r == ST_SUM);
    cmd.mul_mv  = (state_r == ST_MUL_MV);
    cmd.finish  = finish_go;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_MUL_OLD;
      ST_MUL_OLD: state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_MUL_MV;
      ST_MUL_MV:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (finish_go) state_nxt = accept ? ST_MUL_OLD : ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[design/mcis_datapath.sv]
// Datapath: settings, per-channel history, shared multiplier and output word.
`timescale 1ns / 1ps

module mcis_datapath #(
  parameter int CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mcis_pkg::cmd_t                      cmd,
  output mcis_pkg::status_t                   status,
  input  mcis_pkg::in_word_t                  in_word,
  input  logic                                cfg_we,
  input  logic [mcis_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mcis_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                out_stall,
  output logic                                out_valid,
  output mcis_pkg::out_word_t                 out_word
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [mcis_pkg::Q15_W-1:0]  weight_new_r;
  logic [mcis_pkg::Q15_W-1:0]  weight_old_r;
  logic [mcis_pkg::MV_W-1:0]   ref_mv_r;
  logic [mcis_pkg::Q15_W-1:0]  prev_r [CHANNELS];
  logic [mcis_pkg::CH_W-1:0]   ch_r;
  logic [mcis_pkg::PROD_W-1:0] prod_r;
  logic [mcis_pkg::Q15_W-1:0]  acc_r;
  logic [mcis_pkg::Q15_W-1:0]  value_r;
  logic                        sat_r;
  logic                        out_valid_r;
  mcis_pkg::out_word_t         out_r;

  logic                        known;
  logic [IDX_W-1:0]            idx;
  logic [mcis_pkg::Q15_W-1:0]  prev_rd;
  logic [mcis_pkg::OP_A_W-1:0] op_a;
  logic [mcis_pkg::Q15_W-1:0]  op_b;
  logic [mcis_pkg::PROD_W-1:0] prod_nxt;
  logic [mcis_pkg::Q15_W:0]    sum;
  logic [mcis_pkg::Q15_W-1:0]  value_nxt;
  logic [mcis_pkg::MV_W-1:0]   q0;
  logic [16:0]                 r0;
  logic [mcis_pkg::MV_W-1:0]   mv;

  assign known   = (32'(ch_r) < CHANNELS);
  assign idx     = IDX_W'(ch_r);
  assign prev_rd = known ? prev_r[idx] : '0;

  // Operand select for the one shared multiplier.
  always_comb begin
    op_a = {1'b0, in_word.raw_word[mcis_pkg::RAW_W-1:1]};
    op_b = weight_new_r;
    if (cmd.mul_old) begin
      op_a = {1'b0, prev_rd};
      op_b = weight_old_r;
    end else if (cmd.mul_mv) begin
      op_a = {value_r, 1'b0};
      op_b = {2'b00, ref_mv_r};
    end
  end

  assign prod_nxt = mcis_pkg::PROD_W'(op_a) * mcis_pkg::PROD_W'(op_b);

  // Both terms are below 2^15, so an overflow shows in the top bit.
  assign sum       = {1'b0, acc_r} + {1'b0, prod_r[29:15]};
  assign value_nxt = sum[mcis_pkg::Q15_W] ? mcis_pkg::Q15_MAX : sum[mcis_pkg::Q15_W-1:0];

  // Divide by 65535: quotient guess from the high half, one correction step.
  assign q0 = prod_r[28:16];
  assign r0 = {1'b0, prod_r[15:0]} + 17'(q0);
  assign mv = (r0 >= mcis_pkg::MV_DIVISOR) ? q0 + 13'd1 : q0;

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_word        = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_new_r <= mcis_pkg::WEIGHT_NEW_RESET;
      weight_old_r <= mcis_pkg::WEIGHT_OLD_RESET;
      ref_mv_r     <= mcis_pkg::REF_MV_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mcis_pkg::CFG_WEIGHT_NEW: weight_new_r <= cfg_wdata;
        mcis_pkg::CFG_WEIGHT_OLD: weight_old_r <= cfg_wdata;
        mcis_pkg::CFG_REF_MV:     ref_mv_r     <= cfg_wdata[mcis_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) prev_r[k] <= '0;
    end else if (cmd.sum && known) begin
      prev_r[idx] <= value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) ch_r <= in_word.channel;
    if (cmd.load || cmd.mul_old || cmd.mul_mv) prod_r <= prod_nxt;
    if (cmd.mul_old) acc_r <= prod_r[29:15];
    if (cmd.sum) begin
      value_r <= value_nxt;
      sat_r   <= sum[mcis_pkg::Q15_W];
    end
    if (cmd.finish) begin
      out_r.channel_out <= ch_r;
      out_r.filtered    <= value_r;
      out_r.millivolts  <= mv;
      out_r.saturated   <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

endmodule

[design/multichannel_adc_iir_smoother.sv]
// Top level of the multichannel converter IIR smoother.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall / in_word): one word per converter
//   result, carrying the channel number and the raw 16-bit result. The raw
//   value is halved to Q15 and blended with that channel's last output.
//   Output channel (out_valid / out_stall / out_word): one word per input,
//   with the filtered Q15 value, its millivolt scale and a clamp flag.
//   Configuration (cfg_we / cfg_addr / cfg_wdata): index 0 new-sample
//   weight, 1 history weight, 2 reference in mV; other indexes are ignored.
//   Write only while no word is in flight.
// Schedule:
//   An accepted word steps through MUL_OLD, SUM, MUL_MV and FINISH. Three
//   multiplies share one 16x15 multiplier, so no new word is taken mid-way:
//   the next word enters in the cycle the previous result loads.
// Reset (rst_n low, synchronous): weights return to 4096 / 28672, the
//   reference to 3300 mV, all channel histories clear, the output empties
//   and in_stall is held high.
// Back-pressure: while out_stall holds a result, the next word finishes its
//   math and waits; input is refused until the output slot frees.
//
module multichannel_adc_iir_smoother #(
  parameter int CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mcis_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mcis_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [mcis_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mcis_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mcis_pkg::cmd_t    cmd;
  mcis_pkg::status_t status;

  // Sequencer: one step per cycle through the multiplier schedule, holding in FINISH while the output slot is busy.
  mcis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, per-channel history and the output register.
  mcis_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

[design/mcis_checker.sv]
// Port-level assertions for the smoother, bound to the top level.
`timescale 1ns / 1ps

module mcis_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mcis_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed or dropped");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 5))
    else $error("result appeared without a word accepted five cycles before");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.saturated |-> out_word.filtered == mcis_pkg::Q15_MAX)
    else $error("clamp flag set with unclamped value");

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.millivolts != 13'h1FFF)
    else $error("millivolt result out of range");

endmodule

bind multichannel_adc_iir_smoother mcis_checker u_mcis_checker (.*);
